[sv/sprite_quad_vertex_transform_macros.svh]
// Assertion macros shared by the sprite quad transform RTL.
// Depends on nothing; users provide signals named clk and rst_n.
`ifndef SPRITE_QUAD_VERTEX_TRANSFORM_MACROS_SVH
`define SPRITE_QUAD_VERTEX_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQVT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sqvt_pkg.sv]
// Shared types and constants of the sprite quad vertex transform.
// Depends on nothing; every other RTL file refers to it by scoped names.
package sqvt_pkg;

  localparam int WIN_W = 14;
  localparam logic [WIN_W-1:0] WIN_W_RESET = 14'd1920;
  localparam logic [WIN_W-1:0] WIN_H_RESET = 14'd1080;

  localparam int SINE_DEPTH_DEFAULT = 1024;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_WINDOW_WIDTH  = 1'b0;
  localparam logic REG_WINDOW_HEIGHT = 1'b1;

  localparam logic [1:0] CORNER_BR = 2'd3;
  localparam logic [16:0] UV_ONE = 17'd65536;

  // Queue depths.
  localparam int MID_QUEUE_DEPTH = 2;
  localparam int OUT_QUEUE_DEPTH = 2;

  // Restoring divider: 16 quotient bits, 33-bit dividend, 15-bit divisor.
  localparam int DIV_STEPS = 16;
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 15;

  typedef struct packed {
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [16:0]        size_x;
    logic [16:0]        size_y;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        angle;
    logic [16:0]        fill_ratio;
  } in_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [WIN_W-1:0] win_w;
    logic [WIN_W-1:0] win_h;
  } cfg_t;

  // One classified sprite, as it waits between front and back.
  typedef struct packed {
    logic [32:0]        lx;
    logic [16:0]        size_y;
    logic signed [35:0] piv_x;
    logic signed [35:0] piv_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [16:0]        fill;
  } item_t;

endpackage

[sv/sqvt_queue.sv]
// Small register queue used between the front and back and at the output.
// Depends on sqvt_pkg for its default depth.
module sqvt_queue #(
  parameter type T     = logic,
  parameter int  DEPTH = sqvt_pkg::MID_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int Depth = DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  T                mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[sv/sqvt_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on sqvt_pkg for its widths; the dividend must be below divisor * 2^DIV_STEPS.
module sqvt_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [sqvt_pkg::DIV_NUM_W-1:0] in_num,
  input  logic [sqvt_pkg::DIV_DEN_W-1:0] in_den,
  output logic [sqvt_pkg::DIV_STEPS-1:0] out_q
);

  localparam int Steps = sqvt_pkg::DIV_STEPS;
  localparam int NumW  = sqvt_pkg::DIV_NUM_W;
  localparam int DenW  = sqvt_pkg::DIV_DEN_W;

  logic [NumW-1:0]  rem_r [Steps];
  logic [DenW-1:0]  den_r [Steps];
  logic [Steps-1:0] q_r   [Steps];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic [NumW-1:0]  rem_in;
    logic [NumW-1:0]  trial;
    logic [DenW-1:0]  den_in;
    logic [Steps-1:0] q_in;
    logic             take;

    if (j == 0) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign trial = NumW'(den_in) << (Steps - 1 - j);
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? (rem_in - trial) : rem_in;
        den_r[j] <= den_in;
        q_r[j]   <= {q_in[Steps-2:0], take};
      end
    end
  end

  assign out_q = q_r[Steps-1];

endmodule

[sv/sqvt_front.sv]
// Front end: takes a sprite, looks up sine and cosine, forms the per-sprite products.
// Depends on sqvt_pkg; the quarter-wave sine ROM is built here at elaboration.
module sqvt_front #(
  parameter int SINE_TABLE_DEPTH = sqvt_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sqvt_pkg::in_t   in_data,
  output logic            full,
  output logic            q_push,
  output sqvt_pkg::item_t q_item,
  input  logic            q_full
);

  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ProdW = 15 + IdxW;

  typedef logic [14:0] rom_t [SINE_TABLE_DEPTH + 1];

  // Long division used only while the ROM is built; every dividend here stays
  // below 2^48.
  function automatic logic [63:0] udiv48(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 47; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k is the sine of 90 degrees times k over the depth, in Q1.14, from a
  // Q2.30 Taylor series.
  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x   = udiv48(64'd1686629713 * 64'(k), 64'(SINE_TABLE_DEPTH));
      t   = x;
      sum = $signed(x);
      for (int n = 1; n <= 12; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = udiv48(t, 64'(2 * n) * 64'(2 * n + 1));
        if (n[0]) begin
          sum = sum - $signed(t);
        end else begin
          sum = sum + $signed(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (64'(sum) + 64'd32768) >> 16;
      if (r > 64'd16384) begin
        r = 64'd16384;
      end
      rom[k] = r[14:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Returns {negate, index} for the sine of a binary angle.
  function automatic logic [IdxW:0] rom_addr(input logic [15:0] a);
    logic [14:0]      ph;
    logic [ProdW-1:0] prod;
    ph = {1'b0, a[13:0]};
    if (a[14]) begin
      ph = 15'd16384 - ph;
    end
    prod = ProdW'(ph) * ProdW'(SINE_TABLE_DEPTH);
    return {a[15], prod[ProdW-2:14]};
  endfunction

  logic               accept;
  logic               s1_valid_r, s1_valid_nxt;
  sqvt_pkg::item_t    item_r;
  logic [14:0]        sin_raw_r, cos_raw_r;
  logic               sin_neg_r, cos_neg_r;
  logic [IdxW:0]      sin_addr, cos_addr;
  logic [16:0]        fill_c;
  logic [33:0]        lx_full;
  logic signed [35:0] pvx_e, pvy_e, szx_e, szy_e;
  logic signed [15:0] sin_mag, cos_mag;

  assign full   = s1_valid_r && q_full;
  assign accept = push && !full;
  assign q_push = s1_valid_r && !q_full;

  assign sin_addr = rom_addr(in_data.angle);
  assign cos_addr = rom_addr(in_data.angle + 16'd16384);

  always_comb begin
    fill_c  = (in_data.fill_ratio > sqvt_pkg::UV_ONE) ? sqvt_pkg::UV_ONE : in_data.fill_ratio;
    lx_full = 34'(in_data.size_x) * 34'(fill_c);
    pvx_e   = 36'(in_data.pivot_x);
    pvy_e   = 36'(in_data.pivot_y);
    szx_e   = 36'({1'b0, in_data.size_x});
    szy_e   = 36'({1'b0, in_data.size_y});
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.lx      <= lx_full[32:0];
      item_r.size_y  <= in_data.size_y;
      item_r.piv_x   <= (pvx_e * szx_e) <<< 2;
      item_r.piv_y   <= (pvy_e * szy_e) <<< 2;
      item_r.scale_x <= in_data.scale_x;
      item_r.scale_y <= in_data.scale_y;
      item_r.sin_v   <= '0;
      item_r.cos_v   <= '0;
      item_r.pos_x   <= in_data.pos_x;
      item_r.pos_y   <= in_data.pos_y;
      item_r.fill    <= fill_c;
      sin_raw_r      <= SINE_ROM[sin_addr[IdxW-1:0]];
      cos_raw_r      <= SINE_ROM[cos_addr[IdxW-1:0]];
      sin_neg_r      <= sin_addr[IdxW];
      cos_neg_r      <= cos_addr[IdxW];
    end
  end

  always_comb begin
    sin_mag      = {1'b0, sin_raw_r};
    cos_mag      = {1'b0, cos_raw_r};
    q_item       = item_r;
    q_item.sin_v = sin_neg_r ? -sin_mag : sin_mag;
    q_item.cos_v = cos_neg_r ? -cos_mag : cos_mag;
  end

endmodule

[sv/sqvt_back.sv]
// Back end: walks the four corners of each sprite through scale, rotate and NDC mapping.
// Depends on sqvt_pkg, sqvt_div, sqvt_queue and the shared assertion macros.
`include "sprite_quad_vertex_transform_macros.svh"

module sqvt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sqvt_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  sqvt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output sqvt_pkg::out_t  out_data
);

  localparam int Steps   = sqvt_pkg::DIV_STEPS;
  localparam int NumW    = sqvt_pkg::DIV_NUM_W;
  localparam int DenW    = sqvt_pkg::DIV_DEN_W;
  localparam int NPipe   = 7 + Steps;
  localparam int LastStg = NPipe - 1;

  localparam logic signed [36:0] VClampHi = 37'sd8388608;
  localparam logic signed [36:0] VClampLo = -37'sd8388608;
  localparam logic signed [15:0] NdcMax   = 16'sd32767;
  localparam logic signed [15:0] NdcMin   = -16'sd32768;

  typedef struct packed {
    logic [1:0]  corner;
    logic [16:0] fill;
  } tag_t;

  typedef struct packed {
    tag_t               tk;
    logic signed [15:0] sin_v;
    logic signed [15:0] cos_v;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
  } meta_t;

  typedef struct packed {
    tag_t tk;
    logic sx;
    logic ox;
    logic sy;
    logic oy;
  } dtag_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return NdcMax;
    end else if (v < -19'sd32768) begin
      return NdcMin;
    end
    return v[15:0];
  endfunction

  logic               adv, issue, of_full, of_push;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [LastStg:0]   vld_r, vld_nxt;
  sqvt_pkg::out_t     res;

  // Stage 0: corner offsets.
  meta_t              meta_r [5];
  logic signed [36:0] dfx0_r, dfy0_r;
  logic signed [15:0] scx0_r, scy0_r;
  logic signed [36:0] lxe, lye, pvxe, pvye;
  meta_t              meta_in;
  // Stage 1: scaled.
  logic signed [52:0] px1_r, py1_r;
  // Stage 2: rounded to Q.12.
  logic signed [36:0] dx2_r, dy2_r;
  // Stage 3: rotation products.
  logic signed [52:0] xc3_r, ys3_r, yc3_r, xs3_r;
  logic signed [53:0] rx_sum, ry_sum, rx_sh, ry_sh;
  // Stage 4: translated, Q.8 pixels.
  logic signed [36:0] vx4_r, vy4_r;
  tag_t               tag5_r;
  // Stage 5: rounding numerators.
  logic signed [36:0] vcx, vcy;
  logic [13:0]        ww, wh;
  logic signed [32:0] num5x_r, num5y_r;
  logic [DenW-1:0]    den5x_r, den5y_r;
  // Stage 6: magnitudes for the divider.
  logic [NumW-1:0]    mx, my;
  logic [NumW-1:0]    m6x_r, m6y_r;
  logic [DenW-1:0]    den6x_r, den6y_r;
  dtag_t              dtag_r [Steps + 1];
  dtag_t              dtag_in;
  dtag_t              dtag_out;
  logic [Steps-1:0]   qx, qy;
  logic signed [17:0] qxe, qye, qxv, qyv;

  assign adv   = !of_full;
  assign issue = adv && !q_empty;
  assign q_pop = issue && (cnt_r == sqvt_pkg::CORNER_BR);

  always_comb begin
    cnt_nxt = issue ? cnt_r + 1'b1 : cnt_r;
    vld_nxt = adv ? {vld_r[LastStg-1:0], issue} : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    lxe  = cnt_r[0] ? 37'(q_item.lx) : '0;
    lye  = cnt_r[1] ? 37'({q_item.size_y, 16'h0000}) : '0;
    pvxe = 37'(q_item.piv_x);
    pvye = 37'(q_item.piv_y);
    meta_in.tk.corner = cnt_r;
    meta_in.tk.fill   = q_item.fill;
    meta_in.sin_v     = q_item.sin_v;
    meta_in.cos_v     = q_item.cos_v;
    meta_in.pos_x     = q_item.pos_x;
    meta_in.pos_y     = q_item.pos_y;
  end

  always_comb begin
    rx_sum = 54'(xc3_r) + 54'(ys3_r) + 54'sd131072;
    ry_sum = 54'(yc3_r) - 54'(xs3_r) + 54'sd131072;
    rx_sh  = rx_sum >>> 18;
    ry_sh  = ry_sum >>> 18;
  end

  always_comb begin
    ww  = (cfg.win_w == '0) ? 14'd1 : cfg.win_w;
    wh  = (cfg.win_h == '0) ? 14'd1 : cfg.win_h;
    vcx = (vx4_r > VClampHi) ? VClampHi : ((vx4_r < VClampLo) ? VClampLo : vx4_r);
    vcy = (vy4_r > VClampHi) ? VClampHi : ((vy4_r < VClampLo) ? VClampLo : vy4_r);
  end

  // Floor division of a negative numerator goes through -num + den - 1.
  always_comb begin
    mx = num5x_r[32] ? (NumW'(-num5x_r) + NumW'(den5x_r) - 1'b1) : NumW'(num5x_r);
    my = num5y_r[32] ? (NumW'(-num5y_r) + NumW'(den5y_r) - 1'b1) : NumW'(num5y_r);
    dtag_in.tk = tag5_r;
    dtag_in.sx = num5x_r[32];
    dtag_in.sy = num5y_r[32];
    dtag_in.ox = (mx >= (NumW'(den5x_r) << Steps));
    dtag_in.oy = (my >= (NumW'(den5y_r) << Steps));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dfx0_r    <= lxe - pvxe;
      dfy0_r    <= lye - pvye;
      scx0_r    <= q_item.scale_x;
      scy0_r    <= q_item.scale_y;
      meta_r[0] <= meta_in;
      for (int i = 1; i < 5; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      px1_r   <= 53'(dfx0_r) * 53'(scx0_r);
      py1_r   <= 53'(dfy0_r) * 53'(scy0_r);
      dx2_r   <= 37'((px1_r + 53'sd32768) >>> 16);
      dy2_r   <= 37'((py1_r + 53'sd32768) >>> 16);
      xc3_r   <= 53'(dx2_r) * 53'(meta_r[2].cos_v);
      ys3_r   <= 53'(dy2_r) * 53'(meta_r[2].sin_v);
      yc3_r   <= 53'(dy2_r) * 53'(meta_r[2].cos_v);
      xs3_r   <= 53'(dx2_r) * 53'(meta_r[2].sin_v);
      vx4_r   <= 37'(rx_sh) + (37'(meta_r[3].pos_x) <<< 4);
      vy4_r   <= 37'(ry_sh) + (37'(meta_r[3].pos_y) <<< 4);
      tag5_r  <= meta_r[4].tk;
      num5x_r <= (33'(vcx) <<< 8) + 33'({1'b0, ww});
      num5y_r <= (33'(vcy) <<< 8) + 33'({1'b0, wh});
      den5x_r <= {ww, 1'b0};
      den5y_r <= {wh, 1'b0};
      m6x_r   <= mx;
      m6y_r   <= my;
      den6x_r <= den5x_r;
      den6y_r <= den5y_r;
      dtag_r[0] <= dtag_in;
      for (int i = 1; i <= Steps; i++) begin
        dtag_r[i] <= dtag_r[i-1];
      end
    end
  end

  sqvt_div u_div_x (
    .clk    (clk),
    .en     (adv),
    .in_num (m6x_r),
    .in_den (den6x_r),
    .out_q  (qx)
  );

  sqvt_div u_div_y (
    .clk    (clk),
    .en     (adv),
    .in_num (m6y_r),
    .in_den (den6y_r),
    .out_q  (qy)
  );

  always_comb begin
    dtag_out = dtag_r[Steps];
    qxe      = 18'({2'b00, qx});
    qye      = 18'({2'b00, qy});
    qxv      = dtag_out.sx ? -qxe : qxe;
    qyv      = dtag_out.sy ? -qye : qye;
    res.corner = dtag_out.tk.corner;
    if (dtag_out.ox) begin
      res.ndc_x = dtag_out.sx ? NdcMin : NdcMax;
    end else begin
      res.ndc_x = sat16(19'(qxv) - 19'sd16384);
    end
    if (dtag_out.oy) begin
      res.ndc_y = dtag_out.sy ? NdcMax : NdcMin;
    end else begin
      res.ndc_y = sat16(19'sd16384 - 19'(qyv));
    end
    res.tex_u = dtag_out.tk.corner[0] ? dtag_out.tk.fill : '0;
    res.tex_v = dtag_out.tk.corner[1] ? sqvt_pkg::UV_ONE : '0;
    res.last  = (dtag_out.tk.corner == sqvt_pkg::CORNER_BR);
  end

  assign of_push = vld_r[LastStg] && adv;

  sqvt_queue #(
    .T     (sqvt_pkg::out_t),
    .DEPTH (sqvt_pkg::OUT_QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (of_push),
    .wdata (res),
    .full  (of_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  `SQVT_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_r), "pipeline moved while stalled")
  `SQVT_ASSERT_SAME(a_last_flag, !empty, out_data.last == (out_data.corner == sqvt_pkg::CORNER_BR), "last flag not on the fourth corner")
  `SQVT_ASSERT_SAME(a_ovf_sat, of_push && dtag_out.ox, (res.ndc_x == NdcMax) || (res.ndc_x == NdcMin), "overflowed quotient not saturated")

endmodule

[sv/sprite_quad_vertex_transform.sv]
// Top level of the sprite quad vertex transform: configuration registers and the
// front, queue and back parts. Depends on sqvt_pkg, sqvt_front, sqvt_queue, sqvt_back.

// Each sprite pushed in comes out as four corner beats in Z order (top-left,
// top-right, bottom-left, bottom-right), the fourth marked with last. The back
// end starts one corner per cycle through its scale, rotate and divide
// pipeline while its output queue has room and a sprite waits for it; a new
// sprite can be pushed while the corners of earlier ones are still in flight
// or wait to be popped. The front end registers one sprite, reads sine and
// cosine from a quarter-wave ROM of SINE_TABLE_DEPTH+1 entries and forms the
// per-sprite products; a two-entry queue then separates it from the back end.
// The NDC mapping divides by twice the window size in a 16-stage restoring
// divider per axis. Window width and height sit at byte addresses 0 and 4 of
// the APB port, reset to 1920 and 1080; a value of zero is used as one. They
// may only be changed while no sprite is in flight. Output coordinates
// saturate to the Q2.14 range.
module sprite_quad_vertex_transform #(
  parameter int SINE_TABLE_DEPTH = sqvt_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  sqvt_pkg::in_t                   in_data,
  output logic                            full,
  input  logic                            pop,
  output sqvt_pkg::out_t                  out_data,
  output logic                            empty,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sqvt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sqvt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sqvt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [sqvt_pkg::WIN_W-1:0] win_w_r, win_w_nxt;
  logic [sqvt_pkg::WIN_W-1:0] win_h_r, win_h_nxt;
  logic                       cfg_wr;
  sqvt_pkg::cfg_t             cfg;
  logic                       mq_push, mq_full, mq_pop, mq_empty;
  sqvt_pkg::item_t            mq_wdata, mq_rdata;

  // The register file answers every access at once.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    win_w_nxt = win_w_r;
    win_h_nxt = win_h_r;
    if (cfg_wr) begin
      case (paddr[2])
        sqvt_pkg::REG_WINDOW_WIDTH: begin
          win_w_nxt = pwdata[sqvt_pkg::WIN_W-1:0];
        end
        sqvt_pkg::REG_WINDOW_HEIGHT: begin
          win_h_nxt = pwdata[sqvt_pkg::WIN_W-1:0];
        end
        default: begin
          win_w_nxt = win_w_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= sqvt_pkg::WIN_W_RESET;
      win_h_r <= sqvt_pkg::WIN_H_RESET;
    end else begin
      win_w_r <= win_w_nxt;
      win_h_r <= win_h_nxt;
    end
  end

  // Reads return the addressed register, zero extended.
  always_comb begin
    case (paddr[2])
      sqvt_pkg::REG_WINDOW_WIDTH:  prdata = sqvt_pkg::APB_DATA_W'(win_w_r);
      sqvt_pkg::REG_WINDOW_HEIGHT: prdata = sqvt_pkg::APB_DATA_W'(win_h_r);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.win_w = win_w_r;
  assign cfg.win_h = win_h_r;

  sqvt_front #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_push  (mq_push),
    .q_item  (mq_wdata),
    .q_full  (mq_full)
  );

  sqvt_queue #(
    .T (sqvt_pkg::item_t)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  sqvt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .q_empty  (mq_empty),
    .q_item   (mq_rdata),
    .q_pop    (mq_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
